>>> rtl/fccr_pkg.sv
// ----------------------------------------------------------------------------
// fccr_pkg: shared types and constants of the fat12 cluster chain reader
// Field widths, item kind codes, status codes, register indexes and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package fccr_pkg;

    localparam int KIND_W    = 2;
    localparam int TADDR_W   = 13;
    localparam int CLUSTER_W = 12;
    localparam int SIZE_W    = 32;
    localparam int SECTOR_W  = 20;
    localparam int SCOUNT_W  = 8;
    localparam int BCOUNT_W  = 20;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_START = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NEXT  = 2'd2;

    // result status
    localparam logic [STATUS_W-1:0] STAT_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NO_CHAIN    = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_LOW_CLUSTER = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BPS_LOG2      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPC_LOG2      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SECTORS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_COPIES  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_ENTRIES  = 3'd5;

    localparam logic [CLUSTER_W-1:0] ENTRY_END_MARK = 12'hFF8;

    typedef struct packed {
        logic load_wr;   // write a table byte
        logic start;     // open a file chain
        logic rd_en;     // read one table byte
        logic rd_hi;     // read the second byte of the entry
        logic take_en;   // capture the low byte and the clipped byte count
        logic commit;    // build the result and update the chain
    } fccr_cmd_t;

    typedef struct packed {
        logic out_free;  // output register can take a result this cycle
    } fccr_stat_t;

endpackage

`default_nettype wire

>>> rtl/fccr_if.sv
// ----------------------------------------------------------------------------
// fccr channel interfaces
// Input item channel, result channel and register write channel, each with
// valid and ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface fccr_req_if import fccr_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [KIND_W-1:0]    kind;
    logic [TADDR_W-1:0]   table_address;
    logic [7:0]           table_byte;
    logic [CLUSTER_W-1:0] first_cluster;
    logic [SIZE_W-1:0]    file_size;

    modport source (output valid, kind, table_address, table_byte, first_cluster,
                    file_size, input ready);
    modport sink   (input valid, kind, table_address, table_byte, first_cluster,
                    file_size, output ready);
endinterface

interface fccr_rsp_if import fccr_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [SECTOR_W-1:0]  extent_sector;
    logic [SCOUNT_W-1:0]  sector_count;
    logic [BCOUNT_W-1:0]  byte_count;
    logic [CLUSTER_W-1:0] cluster_number;
    logic                 last_extent;
    logic [STATUS_W-1:0]  status;

    modport source (output valid, extent_sector, sector_count, byte_count,
                    cluster_number, last_extent, status, input ready);
    modport sink   (input valid, extent_sector, sector_count, byte_count,
                    cluster_number, last_extent, status, output ready);
endinterface

interface fccr_cfg_if import fccr_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/fccr_ctrl.sv
// ----------------------------------------------------------------------------
// fccr_ctrl: item sequencer
// Takes load and start items while idle; walks a next item through the
// two table byte reads and the result commit.
// ----------------------------------------------------------------------------
`default_nettype none

module fccr_ctrl import fccr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              valid,
    input  wire logic [KIND_W-1:0] kind,
    output logic                   ready,
    input  wire fccr_stat_t        stat,
    output fccr_cmd_t              cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        ready      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                ready     = 1'b1;
                // low byte of the current entry is fetched speculatively
                cmd.rd_en = 1'b1;
                if (valid)
                begin
                    unique case (kind)
                        KIND_LOAD:  cmd.load_wr = 1'b1;
                        KIND_START: cmd.start   = 1'b1;
                        KIND_NEXT:  state_next  = S_READ;
                        default:    ;
                    endcase
                end
            end
            S_READ:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_hi   = 1'b1;
                cmd.take_en = 1'b1;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

>>> rtl/fccr_dp.sv
// ----------------------------------------------------------------------------
// fccr_dp: table memory, geometry registers and chain datapath
// Holds the allocation table, the volume geometry and the open chain, and
// builds one extent per next item into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fccr_dp import fccr_pkg::*;
#(
    parameter int TABLE_BYTES = 8192
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire fccr_cmd_t            cmd,
    output fccr_stat_t                stat,
    input  wire logic [TADDR_W-1:0]   table_address,
    input  wire logic [7:0]           table_byte,
    input  wire logic [CLUSTER_W-1:0] first_cluster,
    input  wire logic [SIZE_W-1:0]    file_size,
    fccr_cfg_if.sink                  cfg,
    fccr_rsp_if.source                rsp
);

    localparam int AW = $clog2(TABLE_BYTES);

    // geometry registers
    logic [3:0]  bps_log2_reg, bps_log2_next;
    logic [2:0]  spc_log2_reg, spc_log2_next;
    logic [15:0] reserved_reg, reserved_next;
    logic [4:0]  tbl_sectors_reg, tbl_sectors_next;
    logic [2:0]  tbl_copies_reg, tbl_copies_next;
    logic [15:0] root_entries_reg, root_entries_next;

    // chain state
    logic [CLUSTER_W-1:0] cluster_reg, cluster_next;
    logic [SIZE_W-1:0]    bytes_left_reg, bytes_left_next;
    logic                 active_reg, active_next;
    logic [SECTOR_W-1:0]  data_start_reg, data_start_next;

    // table read path
    logic [7:0]           mem [TABLE_BYTES];
    logic [7:0]           rd_data_reg;
    logic                 rd_oob_reg;
    logic [7:0]           lo_reg;
    logic [BCOUNT_W-1:0]  take_reg;

    // output register
    logic                 rsp_valid_reg, rsp_valid_next;
    logic [SECTOR_W-1:0]  sector_reg;
    logic [SCOUNT_W-1:0]  scount_reg;
    logic [BCOUNT_W-1:0]  bcount_reg;
    logic [CLUSTER_W-1:0] cnum_reg;
    logic                 last_reg;
    logic [STATUS_W-1:0]  status_reg;

    logic [3:0]           sh;
    logic [12:0]          bps_m1;
    logic [21:0]          root_sum;
    logic [21:0]          root_secs;
    logic [7:0]           tbl_total;
    logic [SECTOR_W-1:0]  ds_calc;
    logic [TADDR_W-1:0]   entry_idx;
    logic [TADDR_W-1:0]   rd_idx;
    logic                 rd_in;
    logic [AW-1:0]        rd_addr;
    logic                 wr_in;
    logic [7:0]           rd_byte;
    logic [BCOUNT_W-1:0]  cluster_bytes;
    logic [BCOUNT_W-1:0]  take_calc;
    logic [20:0]          secs_sum;
    logic [CLUSTER_W-1:0] cl_m2;
    logic [SECTOR_W-1:0]  sector_calc;
    logic [CLUSTER_W-1:0] next_entry;
    logic                 is_last;
    logic                 low_cluster;
    logic [SECTOR_W-1:0]  res_sector;
    logic [SCOUNT_W-1:0]  res_scount;
    logic [BCOUNT_W-1:0]  res_bcount;
    logic                 res_last;
    logic [STATUS_W-1:0]  res_status;

    // sector size clamped to 512..4096
    always_comb
    begin
        priority if (bps_log2_reg < 4'd9)
            sh = 4'd9;
        else if (bps_log2_reg > 4'd12)
            sh = 4'd12;
        else
            sh = bps_log2_reg;
    end

    assign bps_m1    = 13'((14'd1 << sh) - 14'd1);
    assign root_sum  = {1'b0, root_entries_reg, 5'b0} + 22'(bps_m1);
    assign root_secs = root_sum >> sh;
    assign tbl_total = 8'(tbl_sectors_reg * tbl_copies_reg);
    assign ds_calc   = SECTOR_W'(24'(reserved_reg) + 24'(tbl_total) + 24'(root_secs));

    // packed entry offset: cluster * 1.5
    assign entry_idx = TADDR_W'({1'b0, cluster_reg} + {2'b0, cluster_reg[CLUSTER_W-1:1]});
    assign rd_idx    = cmd.rd_hi ? entry_idx + TADDR_W'(1) : entry_idx;
    assign rd_in     = 32'(rd_idx) < 32'(TABLE_BYTES);
    assign rd_addr   = rd_in ? rd_idx[AW-1:0] : '0;
    assign wr_in     = 32'(table_address) < 32'(TABLE_BYTES);
    assign rd_byte   = rd_oob_reg ? 8'd0 : rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_wr && wr_in)
            mem[table_address[AW-1:0]] <= table_byte;
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_oob_reg  <= !rd_in;
        end
        if (cmd.take_en)
        begin
            lo_reg   <= rd_byte;
            take_reg <= take_calc;
        end
    end

    // bytes of this cluster that still belong to the file
    assign cluster_bytes = BCOUNT_W'(1) << (5'(sh) + 5'(spc_log2_reg));
    assign take_calc     = (32'(cluster_bytes) < bytes_left_reg) ? cluster_bytes
                                                                 : bytes_left_reg[BCOUNT_W-1:0];

    assign secs_sum    = (21'(take_reg) + 21'(bps_m1)) >> sh;
    assign cl_m2       = cluster_reg - CLUSTER_W'(2);
    assign sector_calc = data_start_reg + SECTOR_W'(19'(cl_m2) << spc_log2_reg);
    assign next_entry  = cluster_reg[0] ? {rd_byte, lo_reg[7:4]} : {rd_byte[3:0], lo_reg};
    assign is_last     = next_entry >= ENTRY_END_MARK;
    assign low_cluster = cluster_reg < CLUSTER_W'(2);

    always_comb
    begin
        res_sector = '0;
        res_scount = '0;
        res_bcount = '0;
        res_last   = 1'b0;
        res_status = STAT_OK;
        priority if (!active_reg)
            res_status = STAT_NO_CHAIN;
        else if (low_cluster)
        begin
            res_last   = 1'b1;
            res_status = STAT_LOW_CLUSTER;
        end
        else
        begin
            res_sector = sector_calc;
            res_scount = secs_sum[SCOUNT_W-1:0];
            res_bcount = take_reg;
            res_last   = is_last;
        end
    end

    // register writes and chain update
    always_comb
    begin
        bps_log2_next     = bps_log2_reg;
        spc_log2_next     = spc_log2_reg;
        reserved_next     = reserved_reg;
        tbl_sectors_next  = tbl_sectors_reg;
        tbl_copies_next   = tbl_copies_reg;
        root_entries_next = root_entries_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_BPS_LOG2:      bps_log2_next     = cfg.data[3:0];
                CFG_SPC_LOG2:      spc_log2_next     = cfg.data[2:0];
                CFG_RESERVED:      reserved_next     = cfg.data;
                CFG_TABLE_SECTORS: tbl_sectors_next  = cfg.data[4:0];
                CFG_TABLE_COPIES:  tbl_copies_next   = cfg.data[2:0];
                CFG_ROOT_ENTRIES:  root_entries_next = cfg.data;
                default:           ;
            endcase
        end

        cluster_next    = cluster_reg;
        bytes_left_next = bytes_left_reg;
        active_next     = active_reg;
        data_start_next = data_start_reg;
        priority if (cmd.start)
        begin
            cluster_next    = first_cluster;
            bytes_left_next = file_size;
            active_next     = 1'b1;
            data_start_next = ds_calc;
        end
        else if (cmd.commit && active_reg)
        begin
            if (low_cluster)
                active_next = 1'b0;
            else
            begin
                bytes_left_next = bytes_left_reg - 32'(take_reg);
                if (is_last)
                    active_next = 1'b0;
                else
                    cluster_next = next_entry;
            end
        end

        rsp_valid_next = rsp_valid_reg;
        priority if (cmd.commit)
            rsp_valid_next = 1'b1;
        else if (rsp.ready)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bps_log2_reg     <= 4'd9;
            spc_log2_reg     <= 3'd0;
            reserved_reg     <= 16'd1;
            tbl_sectors_reg  <= 5'd9;
            tbl_copies_reg   <= 3'd2;
            root_entries_reg <= 16'd224;
            cluster_reg      <= '0;
            bytes_left_reg   <= '0;
            active_reg       <= 1'b0;
            data_start_reg   <= '0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            bps_log2_reg     <= bps_log2_next;
            spc_log2_reg     <= spc_log2_next;
            reserved_reg     <= reserved_next;
            tbl_sectors_reg  <= tbl_sectors_next;
            tbl_copies_reg   <= tbl_copies_next;
            root_entries_reg <= root_entries_next;
            cluster_reg      <= cluster_next;
            bytes_left_reg   <= bytes_left_next;
            active_reg       <= active_next;
            data_start_reg   <= data_start_next;
            rsp_valid_reg    <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            sector_reg <= res_sector;
            scount_reg <= res_scount;
            bcount_reg <= res_bcount;
            cnum_reg   <= active_reg ? cluster_reg : '0;
            last_reg   <= res_last;
            status_reg <= res_status;
        end
    end

    assign stat.out_free = !rsp_valid_reg || rsp.ready;

    assign cfg.ready          = 1'b1;
    assign rsp.valid          = rsp_valid_reg;
    assign rsp.extent_sector  = sector_reg;
    assign rsp.sector_count   = scount_reg;
    assign rsp.byte_count     = bcount_reg;
    assign rsp.cluster_number = cnum_reg;
    assign rsp.last_extent    = last_reg;
    assign rsp.status         = status_reg;

endmodule

`default_nettype wire

>>> rtl/fat12_cluster_chain_reader.sv
// ----------------------------------------------------------------------------
// fat12_cluster_chain_reader: FAT12 cluster chain walker
// Loads a FAT12 allocation table and emits one extent per next item.
// ----------------------------------------------------------------------------
// Load and start items are taken while the block is idle and give no result. A
// next item is handled in order: the two bytes of the packed 12-bit entry are
// read one after the other through the single read port of the table memory,
// then the extent is built into the output register. A result waiting in the
// output register does not hold off the next item; only a second result
// finding it still full stalls in the last step. The table memory needs no
// clearing after reset: entries read before they are written are undefined.
// Register writes are taken in any cycle and must only be issued while the
// block is idle.
`default_nettype none

module fat12_cluster_chain_reader import fccr_pkg::*;
#(
    parameter int TABLE_BYTES = 8192
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    fccr_req_if.sink   req,
    fccr_rsp_if.source rsp,
    fccr_cfg_if.sink   cfg
);

    fccr_cmd_t  cmd;
    fccr_stat_t stat;

    fccr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .valid (req.valid),
        .kind  (req.kind),
        .ready (req.ready),
        .stat  (stat),
        .cmd   (cmd)
    );

    fccr_dp #(
        .TABLE_BYTES (TABLE_BYTES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .table_address (req.table_address),
        .table_byte    (req.table_byte),
        .first_cluster (req.first_cluster),
        .file_size     (req.file_size),
        .cfg           (cfg),
        .rsp           (rsp)
    );

`ifndef SYNTHESIS
    // a result is never written over one that has not been taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!rsp.valid || rsp.ready))
        else $error("result committed into a full output register");

    // a next item keeps the input side closed for its read and commit cycles
    a_next_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && req.kind == KIND_NEXT) |=> !req.ready ##1 !req.ready)
        else $error("input accepted during a next item");

    // every commit shows up as a valid result
    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> rsp.valid)
        else $error("committed result not presented");

    // no commit and no second-byte read while the input side is open
    a_commit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> !cmd.commit && !cmd.rd_hi)
        else $error("sequencer overlap with input acceptance");
`endif

endmodule

`default_nettype wire

>>> tb/sv/fccr_extent_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fccr_extent_checker: extent predictor and scoreboard
// Watches the item, result and register channels of the cluster chain
// reader. It keeps its own copy of the allocation table, the chain state and
// the geometry registers, predicts the extent that each next item yields and
// compares every accepted result against the oldest predicted extent.
// ----------------------------------------------------------------------------

module fccr_extent_checker import fccr_pkg::*;
#(
    parameter int FAT_BYTES = 8192
)
(
    input  logic clk,
    input  logic rst_n,
    fccr_req_if  req,
    fccr_rsp_if  rsp,
    fccr_cfg_if  cfg,
    output int   fail_count,
    output int   pending_count,
    output int   extents_checked
);

    typedef struct packed {
        logic [SECTOR_W-1:0]  sector;
        logic [SCOUNT_W-1:0]  scount;
        logic [BCOUNT_W-1:0]  bcount;
        logic [CLUSTER_W-1:0] cluster;
        logic                 last;
        logic [STATUS_W-1:0]  status;
    } extent_t;

    logic [7:0] fat_mem [FAT_BYTES];

    // chain walk state
    logic [CLUSTER_W-1:0] walk_cluster;
    logic [31:0]          walk_bytes_left;
    logic                 walk_active;
    logic [SECTOR_W-1:0]  walk_data_start;

    // volume geometry
    logic [3:0]  r_bps_log2;
    logic [2:0]  r_spc_log2;
    logic [15:0] r_reserved;
    logic [4:0]  r_table_sectors;
    logic [2:0]  r_table_copies;
    logic [15:0] r_root_entries;

    extent_t expected_extents [$];
    int      fails;
    int      checked;

    function automatic logic [31:0] sector_shift();
        if (r_bps_log2 < 4'd9)
            return 32'd9;
        if (r_bps_log2 > 4'd12)
            return 32'd12;
        return 32'(r_bps_log2);
    endfunction

    function automatic logic [31:0] fat_read(logic [31:0] addr);
        if (addr >= 32'(FAT_BYTES))
            return 32'd0;
        return 32'(fat_mem[addr]);
    endfunction

    task automatic apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        case (idx)
            CFG_BPS_LOG2:      r_bps_log2      = data[3:0];
            CFG_SPC_LOG2:      r_spc_log2      = data[2:0];
            CFG_RESERVED:      r_reserved      = data;
            CFG_TABLE_SECTORS: r_table_sectors = data[4:0];
            CFG_TABLE_COPIES:  r_table_copies  = data[2:0];
            CFG_ROOT_ENTRIES:  r_root_entries  = data;
            default: ;
        endcase
    endtask

    task automatic predict_item(logic [KIND_W-1:0] kind, logic [TADDR_W-1:0] addr,
                                logic [7:0] byte_v, logic [CLUSTER_W-1:0] cl,
                                logic [SIZE_W-1:0] size);
        logic [31:0] sh;
        logic [31:0] bps;
        logic [31:0] root_secs;
        logic [31:0] data_start;
        logic [31:0] cl32;
        logic [31:0] sector;
        logic [31:0] cl_bytes;
        logic [31:0] take;
        logic [31:0] secs;
        logic [31:0] idx;
        logic [31:0] pair;
        logic [31:0] nxt;
        extent_t     e;
        sh = sector_shift();
        case (kind)
            KIND_LOAD:
            begin
                if (32'(addr) < 32'(FAT_BYTES))
                    fat_mem[addr] = byte_v;
            end
            KIND_START:
            begin
                bps = 32'd1 << sh;
                root_secs = ({16'd0, r_root_entries} * 32'd32 + bps - 32'd1) >> sh;
                data_start = {16'd0, r_reserved}
                           + 32'(r_table_sectors) * 32'(r_table_copies) + root_secs;
                walk_cluster    = cl;
                walk_bytes_left = size;
                walk_active     = 1'b1;
                walk_data_start = data_start[SECTOR_W-1:0];
            end
            KIND_NEXT:
            begin
                e = '0;
                if (!walk_active)
                begin
                    e.status = STAT_NO_CHAIN;
                end
                else if (walk_cluster < 12'd2)
                begin
                    e.cluster   = walk_cluster;
                    e.last      = 1'b1;
                    e.status    = STAT_LOW_CLUSTER;
                    walk_active = 1'b0;
                end
                else
                begin
                    cl32     = 32'(walk_cluster);
                    sector   = 32'(walk_data_start) + ((cl32 - 32'd2) << r_spc_log2);
                    cl_bytes = 32'd1 << (sh + 32'(r_spc_log2));
                    take     = (cl_bytes < walk_bytes_left) ? cl_bytes : walk_bytes_left;
                    secs     = (take + (32'd1 << sh) - 32'd1) >> sh;
                    // packed 12-bit entry: even clusters take the low nibbles
                    idx      = (cl32 * 32'd3) >> 1;
                    pair     = fat_read(idx) | (fat_read(idx + 32'd1) << 8);
                    nxt      = walk_cluster[0] ? (pair >> 4) : (pair & 32'hFFF);
                    walk_bytes_left = walk_bytes_left - take;
                    e.sector  = sector[SECTOR_W-1:0];
                    e.scount  = secs[SCOUNT_W-1:0];
                    e.bcount  = take[BCOUNT_W-1:0];
                    e.cluster = walk_cluster;
                    e.status  = STAT_OK;
                    e.last    = (nxt >= 32'(ENTRY_END_MARK));
                    if (e.last)
                        walk_active = 1'b0;
                    else
                        walk_cluster = nxt[CLUSTER_W-1:0];
                end
                expected_extents.push_back(e);
            end
            default: ;
        endcase
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    task automatic compare_extent(extent_t got);
        extent_t want;
        if (expected_extents.size() == 0)
        begin
            $error("extent with no item waiting: cluster %0d status %0d",
                   got.cluster, got.status);
            fails++;
        end
        else
        begin
            want = expected_extents.pop_front();
            checked++;
            check_field("extent_sector",  32'(want.sector),  32'(got.sector));
            check_field("sector_count",   32'(want.scount),  32'(got.scount));
            check_field("byte_count",     32'(want.bcount),  32'(got.bcount));
            check_field("cluster_number", 32'(want.cluster), 32'(got.cluster));
            check_field("last_extent",    32'(want.last),    32'(got.last));
            check_field("status",         32'(want.status),  32'(got.status));
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            walk_cluster    = '0;
            walk_bytes_left = '0;
            walk_active     = 1'b0;
            walk_data_start = '0;
            r_bps_log2      = 4'd9;
            r_spc_log2      = 3'd0;
            r_reserved      = 16'd1;
            r_table_sectors = 5'd9;
            r_table_copies  = 3'd2;
            r_root_entries  = 16'd224;
            expected_extents.delete();
            fails   = 0;
            checked = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
                compare_extent({rsp.extent_sector, rsp.sector_count, rsp.byte_count,
                                rsp.cluster_number, rsp.last_extent, rsp.status});
            if (cfg.valid && cfg.ready)
                apply_register(cfg.index, cfg.data);
            if (req.valid && req.ready)
                predict_item(req.kind, req.table_address, req.table_byte,
                             req.first_cluster, req.file_size);
        end
        fail_count      <= fails;
        pending_count   <= expected_extents.size();
        extents_checked <= checked;
    end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the fat12 cluster chain reader
// Loads allocation tables, opens files and walks their cluster chains under
// several volume geometries and several patterns of sender gaps and receiver
// stalls. Extents are predicted and checked by the extent checker.
// ----------------------------------------------------------------------------

module tb_top;
    import fccr_pkg::*;

    localparam int FAT_BYTES       = 8192;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 112;
    localparam int DRAIN_CYCLES    = 8;
    localparam int LIMIT_CYCLES    = 400000;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic sink_ready = 1'b0;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int items_sent    = 0;
    int chains_walked = 0;
    int cycle_count   = 0;

    int fail_count;
    int pending_count;
    int extents_checked;

    // what the table holds as far as the stimulus knows, and which bytes are defined
    bit [7:0] fat_image [FAT_BYTES];
    bit       fat_known [FAT_BYTES];

    // chain position as the stimulus tracks it
    bit                   chain_on = 1'b0;
    logic [CLUSTER_W-1:0] chain_cl = '0;

    logic [3:0] cur_bps = 4'd9;
    logic [2:0] cur_spc = 3'd0;

    fccr_req_if req ();
    fccr_rsp_if rsp ();
    fccr_cfg_if cfg ();

    assign rsp.ready = sink_ready;

    fat12_cluster_chain_reader #(
        .TABLE_BYTES (FAT_BYTES)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    fccr_extent_checker #(
        .FAT_BYTES (FAT_BYTES)
    ) extent_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .req             (req),
        .rsp             (rsp),
        .cfg             (cfg),
        .fail_count      (fail_count),
        .pending_count   (pending_count),
        .extents_checked (extents_checked)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
        sink_ready <= (int'($urandom_range(99)) >= stall_pct);

    initial
    begin : watchdog
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    function automatic logic [TADDR_W-1:0] entry_index(logic [CLUSTER_W-1:0] c);
        return TADDR_W'((32'(c) * 32'd3) >> 1);
    endfunction

    function automatic logic [CLUSTER_W-1:0] entry_of(logic [CLUSTER_W-1:0] c);
        logic [TADDR_W-1:0] idx;
        logic [15:0]        pair;
        idx  = entry_index(c);
        pair = {fat_image[idx + 13'd1], fat_image[idx]};
        return c[0] ? pair[15:4] : pair[11:0];
    endfunction

    function automatic logic [CLUSTER_W-1:0] random_entry();
        case ($urandom_range(9))
            0, 1:    return CLUSTER_W'($urandom_range(32'hFF8, 32'hFFF));
            2:       return CLUSTER_W'($urandom_range(1));
            default: return CLUSTER_W'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_size(int unsigned hops);
        logic [31:0] sh;
        logic [31:0] cbytes;
        sh = (cur_bps < 4'd9) ? 32'd9 : ((cur_bps > 4'd12) ? 32'd12 : 32'(cur_bps));
        cbytes = 32'd1 << (sh + 32'(cur_spc));
        case ($urandom_range(5))
            0:       return 32'd0;
            1:       return $urandom_range(1, cbytes * (hops + 1));
            2:       return cbytes * hops;
            3:       return 32'hFFFF_FFFF;
            4:       return $urandom_range(1, 4096);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(logic [KIND_W-1:0] kind, logic [TADDR_W-1:0] addr,
                             logic [7:0] byte_v, logic [CLUSTER_W-1:0] cl,
                             logic [SIZE_W-1:0] size);
        if (send_idle_pct != 0 && int'($urandom_range(99)) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            do
                @(posedge clk);
            while (int'($urandom_range(99)) < send_idle_pct);
        end
        req.valid         <= 1'b1;
        req.kind          <= kind;
        req.table_address <= addr;
        req.table_byte    <= byte_v;
        req.first_cluster <= cl;
        req.file_size     <= size;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        if (kind != KIND_UNUSED)
            items_sent++;
    endtask

    task automatic send_load(logic [TADDR_W-1:0] addr, logic [7:0] byte_v);
        fat_image[addr] = byte_v;
        fat_known[addr] = 1'b1;
        send_item(KIND_LOAD, addr, byte_v, CLUSTER_W'($urandom), $urandom);
    endtask

    task automatic send_start(logic [CLUSTER_W-1:0] cl, logic [SIZE_W-1:0] size);
        chain_on = 1'b1;
        chain_cl = cl;
        send_item(KIND_START, TADDR_W'($urandom), 8'($urandom), cl, size);
    endtask

    // write the packed entry of cluster c, keeping the neighbor's nibble
    task automatic link(logic [CLUSTER_W-1:0] c, logic [CLUSTER_W-1:0] v);
        logic [TADDR_W-1:0] idx;
        logic [7:0]         b0;
        logic [7:0]         b1;
        idx = entry_index(c);
        if (!c[0])
        begin
            b0 = v[7:0];
            b1 = {fat_image[idx + 13'd1][7:4], v[11:8]};
        end
        else
        begin
            b0 = {v[3:0], fat_image[idx][3:0]};
            b1 = v[11:4];
        end
        send_load(idx, b0);
        send_load(idx + 13'd1, b1);
    endtask

    task automatic send_next();
        logic [TADDR_W-1:0]   idx;
        logic [CLUSTER_W-1:0] nxt;
        // never let the block read an entry that was not loaded
        if (chain_on && chain_cl >= 12'd2)
        begin
            idx = entry_index(chain_cl);
            if (!fat_known[idx] || !fat_known[idx + 13'd1])
                link(chain_cl, random_entry());
        end
        send_item(KIND_NEXT, TADDR_W'($urandom), 8'($urandom), CLUSTER_W'($urandom),
                  $urandom);
        if (chain_on)
        begin
            if (chain_cl < 12'd2)
            begin
                chain_on = 1'b0;
            end
            else
            begin
                nxt = entry_of(chain_cl);
                if (nxt >= ENTRY_END_MARK)
                    chain_on = 1'b0;
                else
                    chain_cl = nxt;
            end
        end
    endtask

    task automatic walk_chain();
        logic [CLUSTER_W-1:0] hops [6];
        logic [CLUSTER_W-1:0] tail;
        int unsigned          n;
        int unsigned          i;
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++)
            hops[i] = CLUSTER_W'($urandom_range(2, 4095));
        for (i = 0; i + 1 < n; i++)
            link(hops[i], hops[i + 1]);
        case ($urandom_range(9))
            0:       tail = CLUSTER_W'($urandom_range(1));
            1, 2:    tail = CLUSTER_W'($urandom);
            default: tail = CLUSTER_W'($urandom_range(32'hFF8, 32'hFFF));
        endcase
        link(hops[n - 1], tail);
        if ($urandom_range(19) == 0)
            hops[0] = CLUSTER_W'($urandom_range(1));
        send_start(hops[0], pick_size(n));
        repeat (n + $urandom_range(2))
            send_next();
        chains_walked++;
    endtask

    task automatic noise_item();
        case ($urandom_range(9))
            0, 1, 2, 3, 4: send_load(TADDR_W'($urandom), 8'($urandom));
            5:             send_item(KIND_UNUSED, TADDR_W'($urandom), 8'($urandom),
                                     CLUSTER_W'($urandom), $urandom);
            6, 7:          send_next();
            default:       send_start(CLUSTER_W'($urandom), $urandom);
        endcase
    endtask

    task automatic run_directed();
        send_next();
        send_start(12'd0, 32'd100);
        send_next();
        send_start(12'd1, 32'd0);
        send_next();
        link(12'd2, 12'd3);
        link(12'd3, 12'hFFF);
        send_start(12'd2, 32'hFFFF_FFFF);
        send_next();
        send_next();
        send_next();
        link(12'd4095, 12'd0);
        send_start(12'd4095, 32'd0);
        send_next();
        send_next();
        link(12'd4094, ENTRY_END_MARK);
        send_start(12'd4094, 32'd700);
        send_next();
        send_load(13'd8191, 8'hFF);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
    endtask

    task automatic write_geometry(logic [3:0] bps, logic [2:0] spc, logic [15:0] reserved,
                                  logic [4:0] tsec, logic [2:0] copies, logic [15:0] root);
        write_reg(CFG_BPS_LOG2,      {12'd0, bps});
        write_reg(CFG_SPC_LOG2,      {13'd0, spc});
        write_reg(CFG_RESERVED,      reserved);
        write_reg(CFG_TABLE_SECTORS, {11'd0, tsec});
        write_reg(CFG_TABLE_COPIES,  {13'd0, copies});
        write_reg(CFG_ROOT_ENTRIES,  root);
        cfg.valid <= 1'b0;
        cur_bps = bps;
        cur_spc = spc;
    endtask

    // wait until every extent is back and the block has gone quiet
    task automatic settle();
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        int phase;
        req.valid         <= 1'b0;
        req.kind          <= KIND_LOAD;
        req.table_address <= '0;
        req.table_byte    <= '0;
        req.first_cluster <= '0;
        req.file_size     <= '0;
        cfg.valid         <= 1'b0;
        cfg.index         <= CFG_BPS_LOG2;
        cfg.data          <= '0;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (phase = 0; phase < PHASES; phase++)
        begin
            if (phase != 0)
            begin
                settle();
                case (phase)
                    1: write_geometry(4'd9, 3'd0, 16'd0, 5'd1, 3'd1, 16'd0);
                    2: write_geometry(4'd12, 3'd7, 16'hFFFF, 5'd16, 3'd4, 16'hFFFF);
                    3: write_geometry(4'd15, 3'($urandom), 16'($urandom), 5'd0, 3'd0,
                                      16'($urandom));
                    4: write_geometry(4'($urandom_range(8)), 3'($urandom), 16'($urandom),
                                      5'd31, 3'd7, 16'($urandom));
                    default: write_geometry(4'($urandom), 3'($urandom), 16'($urandom),
                                            5'($urandom), 3'($urandom), 16'($urandom));
                endcase
            end
            case (phase % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 78;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 78;
                end
                default:
                begin
                    send_idle_pct = 8;
                    stall_pct     = 8;
                end
            endcase
            if (phase == 0)
                run_directed();
            while (items_sent < (phase + 1) * ITEMS_PER_PHASE)
            begin
                if ($urandom_range(4) != 0)
                    walk_chain();
                else
                    noise_item();
            end
            req.valid <= 1'b0;
        end

        settle();
        $display("%0d items sent, %0d chains walked over %0d register settings",
                 items_sent, chains_walked, PHASES);
        $display("%0d extents checked, %0d mismatches", extents_checked, fail_count);
        if (fail_count == 0 && pending_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
